// ===== hdl/pkc_pkg.sv =====
// Shared constants and types for the pixel keystream cipher.
package pkc_pkg;

    // Field widths.
    localparam int OP_W   = 2;
    localparam int SEED_W = 31;
    localparam int PIX_W  = 16;
    localparam int DIV_W  = PIX_W + 1;
    localparam int CNT_W  = 5;

    // Park-Miller generator constants.
    localparam int MULT_BITS = 15;
    localparam int MCNT_W    = 4;
    localparam logic [MULT_BITS-1:0] LCG_MULT = 15'd16807;
    localparam logic [SEED_W-1:0]    LCG_MOD  = 31'h7FFF_FFFF;

    // Reset value of the largest grey level.
    localparam logic [PIX_W-1:0] MAX_GREY_RST = 16'd255;

    // Operation codes of an input beat.
    localparam logic [OP_W-1:0] OP_SEED = 2'd0;
    localparam logic [OP_W-1:0] OP_ENC  = 2'd1;
    localparam logic [OP_W-1:0] OP_DEC  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    // Status of a serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

// ===== hdl/pkc_if.sv =====
// Handshake channel interfaces: pixel input, pixel result and configuration write.
interface pkc_in_if import pkc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [SEED_W-1:0] seed_value;
    logic [PIX_W-1:0]  pixel_in;
    logic              last_pixel;

    modport source (output valid, op, seed_value, pixel_in, last_pixel, input ready);
    modport sink   (input valid, op, seed_value, pixel_in, last_pixel, output ready);
endinterface

interface pkc_out_if import pkc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             last_out;

    modport source (output valid, pixel_out, last_out, input ready);
    modport sink   (input valid, pixel_out, last_out, output ready);
endinterface

interface pkc_cfg_if import pkc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/pkc_lcg_mul.sv =====
// Bit-serial modular multiplier that advances the Park-Miller generator.
module pkc_lcg_mul import pkc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SEED_W-1:0] i_state,
    output t_unit_stat        o_stat,
    output logic [SEED_W-1:0] o_next
);

    logic              r_busy;
    logic              r_done;
    logic [MCNT_W-1:0] r_cnt;
    logic [SEED_W-1:0] r_acc;
    logic [SEED_W-1:0] r_s;

    logic [SEED_W-1:0] w_rot;
    logic [SEED_W:0]   w_sum;
    logic [SEED_W:0]   w_red;
    logic [SEED_W-1:0] n_acc;

    // One multiplier bit per cycle, most significant first. Doubling modulo
    // 2^31-1 is a rotate, since 2^31 is congruent to one.
    always_comb begin
        w_rot = {r_acc[SEED_W-2:0], r_acc[SEED_W-1]};
        w_sum = {1'b0, w_rot} + (LCG_MULT[r_cnt] ? {1'b0, r_s} : '0);
        if (w_sum >= {1'b0, LCG_MOD}) begin
            w_red = w_sum - {1'b0, LCG_MOD};
        end else begin
            w_red = w_sum;
        end
        n_acc = w_red[SEED_W-1:0];
    end

    // Sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MCNT_W'(MULT_BITS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Accumulator and operand.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_s   <= i_state;
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_next = r_acc;

endmodule

// ===== hdl/pkc_mod_unit.sv =====
// Bit-serial restoring remainder unit for the modulus max_grey + 1.
module pkc_mod_unit import pkc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SEED_W-1:0] i_dvd,
    input  logic [CNT_W-1:0]  i_nbits,
    input  logic [DIV_W-1:0]  i_dsr,
    output t_unit_stat        o_stat,
    output logic [PIX_W-1:0]  o_rem
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [SEED_W-1:0] r_dvd;
    logic [PIX_W-1:0]  r_rem;

    logic [DIV_W-1:0]  w_trial;
    logic [DIV_W-1:0]  w_diff;
    logic [PIX_W-1:0]  n_rem;

    // Shift in one dividend bit and subtract the divisor when it fits.
    // The partial remainder stays below the divisor, so 16 bits hold it.
    always_comb begin
        w_trial = {r_rem, r_dvd[SEED_W-1]};
        w_diff  = w_trial - i_dsr;
        if (w_trial >= i_dsr) begin
            n_rem = w_diff[PIX_W-1:0];
        end else begin
            n_rem = w_trial[PIX_W-1:0];
        end
    end

    // Sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_nbits - 1'b1;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Dividend shift register and partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dvd;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[SEED_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_rem  = r_rem;

endmodule

// ===== hdl/pixel_keystream_cipher.sv =====
// Top level of the pixel keystream cipher: control, key mixing and output register.
//
// Additive stream cipher for grey-level pixels keyed by the Park-Miller minimal
// standard generator. A seed beat (op 0) loads the generator and gives no result;
// op 3 is dropped. An encode or decode beat first advances the generator in the
// bit-serial multiplier (one bit of 16807 per cycle), then reduces the new state
// modulo max_grey+1 and then the mixed pixel, both in one shared one-bit-per-cycle
// remainder unit, and the result goes to the output register. Pixels are handled
// one at a time; a new beat is taken while the previous result still waits in the
// output register. The user must write max_grey only while the block is idle; the
// block itself does not enforce it.
module pixel_keystream_cipher import pkc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pkc_in_if.sink      i_in,
    pkc_out_if.source   o_out,
    pkc_cfg_if.sink     i_cfg
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_KMOD = 5'b00100,
        S_XMOD = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [PIX_W-1:0]  r_max_grey;
    logic [SEED_W-1:0] r_gen;
    logic              r_dec;
    logic [PIX_W-1:0]  r_pix;
    logic              r_last;
    logic [PIX_W-1:0]  r_res;
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_pix;
    logic              r_out_last;

    logic              w_accept;
    logic              w_pix_op;
    logic              w_out_free;
    logic [DIV_W-1:0]  w_m;
    logic [DIV_W-1:0]  w_x;
    logic              w_mod_start;
    logic [SEED_W-1:0] w_mod_dvd;
    logic [CNT_W-1:0]  w_mod_nbits;
    t_unit_stat        w_mul_stat;
    t_unit_stat        w_mod_stat;
    logic [SEED_W-1:0] w_mul_next;
    logic [PIX_W-1:0]  w_mod_rem;

    // Handshakes.
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_pix_op    = (i_in.op == OP_ENC) || (i_in.op == OP_DEC);
    assign w_out_free  = !r_out_valid || o_out.ready;

    // Modulus and the pixel mixed with the key; the key is below the modulus.
    assign w_m = {1'b0, r_max_grey} + 1'b1;
    always_comb begin
        if (r_dec) begin
            w_x = {1'b0, r_pix} + w_m - {1'b0, w_mod_rem};
        end else begin
            w_x = {1'b0, r_pix} + {1'b0, w_mod_rem};
        end
    end

    // Remainder unit: the new state first, then the mixed pixel, left-aligned.
    always_comb begin
        w_mod_start = 1'b0;
        w_mod_dvd   = w_mul_next;
        w_mod_nbits = CNT_W'(SEED_W);
        if (r_state == S_MUL && w_mul_stat.done) begin
            w_mod_start = 1'b1;
        end else if (r_state == S_KMOD && w_mod_stat.done) begin
            w_mod_start = 1'b1;
            w_mod_dvd   = {w_x, {(SEED_W - DIV_W){1'b0}}};
            w_mod_nbits = CNT_W'(DIV_W);
        end
    end

    pkc_lcg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && w_pix_op),
        .i_state (r_gen),
        .o_stat  (w_mul_stat),
        .o_next  (w_mul_next)
    );

    pkc_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_dvd   (w_mod_dvd),
        .i_nbits (w_mod_nbits),
        .i_dsr   (w_m),
        .o_stat  (w_mod_stat),
        .o_rem   (w_mod_rem)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && w_pix_op) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (w_mul_stat.done) begin
                    n_state = S_KMOD;
                end
            end
            S_KMOD: begin
                if (w_mod_stat.done) begin
                    n_state = S_XMOD;
                end
            end
            S_XMOD: begin
                if (w_mod_stat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, configuration and generator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_grey  <= MAX_GREY_RST;
            r_gen       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_max_grey <= i_cfg.data;
            end
            if (w_accept && i_in.op == OP_SEED) begin
                r_gen <= i_in.seed_value;
            end else if (r_state == S_MUL && w_mul_stat.done) begin
                r_gen <= w_mul_next;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Pixel beat payload and result registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dec  <= (i_in.op == OP_DEC);
            r_pix  <= i_in.pixel_in;
            r_last <= i_in.last_pixel;
        end
        if (r_state == S_XMOD && w_mod_stat.done) begin
            r_res <= w_mod_rem;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_pix  <= r_res;
            r_out_last <= r_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.pixel_out = r_out_pix;
    assign o_out.last_out  = r_out_last;

`ifndef NO_ASSERTIONS
    // A result never exceeds the largest grey level.
    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.pixel_out <= r_max_grey))
        else $error("pixel result above max_grey");

    // The multiplier only works while the controller waits for it.
    a_mul_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mul_stat.busy || w_mul_stat.done) |-> (r_state == S_MUL))
        else $error("multiplier active outside its phase");

    // The remainder unit only works in its two phases.
    a_mod_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mod_stat.busy || w_mod_stat.done) |->
        (r_state == S_KMOD || r_state == S_XMOD))
        else $error("remainder unit active outside its phases");

    // A finished pixel reaches the output register as soon as it is free.
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (o_out.valid && r_state == S_IDLE))
        else $error("finished pixel not moved to the output register");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the pixel keystream cipher: directed table, then random images.
`timescale 1ns / 100ps

module tb;
    import pkc_pkg::*;

    // Run control.
    localparam int          HALF_PERIOD   = 10;
    localparam int          RESET_CYCLES  = 4;
    localparam int          SETTLE_CYCLES = 100;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          STALL_LIMIT   = 4000;
    localparam int          N_PHASES      = 6;
    localparam int unsigned PHASE_ITEMS   = 210;
    localparam int          REPORT_MAX    = 10;
    localparam int          DIR_ROWS      = 29;

    // One input beat as driven on the pixel channel.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SEED_W-1:0] seed;
        logic [PIX_W-1:0]  pix;
        logic              last;
    } t_in_beat;

    // One result beat as expected on the output channel.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_pix_beat;

    // Directed rows are either input beats or a write of the largest grey level.
    typedef enum logic {ROW_BEAT, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [OP_W-1:0]   op;
        logic [SEED_W-1:0] seed;
        logic [PIX_W-1:0]  pix;
        logic              last;
        logic              has_want;
        logic [PIX_W-1:0]  want;
    } t_dir_row;

    // Directed table. For a configuration row the pix column holds the new largest grey.
    // A typed expectation is given where the keystream is zero or the modulus is one.
    t_dir_row directed_rows [DIR_ROWS] = '{
        // Keystream is zero straight after reset.
        '{ROW_BEAT, OP_ENC,  '0,            16'h0000, 1'b0, 1'b1, 16'd0},
        '{ROW_BEAT, OP_ENC,  '0,            16'hFFFF, 1'b1, 1'b1, 16'd255},
        '{ROW_BEAT, OP_DEC,  '0,            16'h0000, 1'b0, 1'b1, 16'd0},
        '{ROW_BEAT, OP_DEC,  '0,            16'd300,  1'b1, 1'b1, 16'd44},
        // Unused op is dropped without touching the generator.
        '{ROW_BEAT, OP_NONE, LCG_MOD,       16'hFFFF, 1'b1, 1'b0, '0},
        '{ROW_BEAT, OP_SEED, 31'd1,         16'h0000, 1'b0, 1'b0, '0},
        '{ROW_BEAT, OP_ENC,  '0,            16'd10,   1'b0, 1'b0, '0},
        '{ROW_BEAT, OP_DEC,  '0,            16'd10,   1'b1, 1'b0, '0},
        // A seed equal to the modulus collapses to zero on the first advance.
        '{ROW_BEAT, OP_SEED, LCG_MOD,       16'h0000, 1'b0, 1'b0, '0},
        '{ROW_BEAT, OP_ENC,  '0,            16'd77,   1'b0, 1'b1, 16'd77},
        '{ROW_BEAT, OP_DEC,  '0,            16'd255,  1'b1, 1'b1, 16'd255},
        '{ROW_BEAT, OP_SEED, 31'h7FFF_FFFE, 16'h0000, 1'b1, 1'b0, '0},
        '{ROW_BEAT, OP_ENC,  '0,            16'hFFFF, 1'b0, 1'b0, '0},
        '{ROW_BEAT, OP_NONE, '0,            16'h0000, 1'b0, 1'b0, '0},
        '{ROW_BEAT, OP_DEC,  '0,            16'h0000, 1'b1, 1'b0, '0},
        // Largest grey of zero makes every result zero.
        '{ROW_CFG,  OP_NONE, '0,            16'd0,    1'b0, 1'b0, '0},
        '{ROW_BEAT, OP_SEED, 31'h5555_5555, 16'h0000, 1'b0, 1'b0, '0},
        '{ROW_BEAT, OP_ENC,  '0,            16'hFFFF, 1'b1, 1'b1, 16'd0},
        '{ROW_BEAT, OP_DEC,  '0,            16'h1234, 1'b0, 1'b1, 16'd0},
        // Full 16-bit range; a zero seed keeps the keystream at zero.
        '{ROW_CFG,  OP_NONE, '0,            16'hFFFF, 1'b0, 1'b0, '0},
        '{ROW_BEAT, OP_SEED, '0,            16'hFFFF, 1'b1, 1'b0, '0},
        '{ROW_BEAT, OP_ENC,  '0,            16'hFFFF, 1'b1, 1'b1, 16'hFFFF},
        '{ROW_BEAT, OP_DEC,  '0,            16'h8000, 1'b0, 1'b1, 16'h8000},
        '{ROW_BEAT, OP_SEED, 31'h2AAA_AAAA, 16'h0000, 1'b0, 1'b0, '0},
        '{ROW_BEAT, OP_ENC,  '0,            16'hAAAA, 1'b0, 1'b0, '0},
        '{ROW_BEAT, OP_DEC,  '0,            16'h5555, 1'b1, 1'b0, '0},
        // Modulus of two, from a largest grey of one.
        '{ROW_CFG,  OP_NONE, '0,            16'd1,    1'b0, 1'b0, '0},
        '{ROW_BEAT, OP_ENC,  '0,            16'd1,    1'b0, 1'b0, '0},
        '{ROW_BEAT, OP_DEC,  '0,            16'hFFFE, 1'b1, 1'b0, '0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Predictor copy of the generator and of the configuration register.
    logic [SEED_W-1:0] lcg_state = '0;
    logic [PIX_W-1:0]  grey_max  = MAX_GREY_RST;

    t_pix_beat   expected_pixels [$];
    int unsigned fail_count    = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    bit          hold_req      = 1'b0;

    pkc_in_if  in_ch ();
    pkc_out_if out_ch ();
    pkc_cfg_if cfg_ch ();

    pixel_keystream_cipher dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Clock with a 20 ns period.
    always begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // Advances the generator and mixes its key into one pixel.
    function automatic t_pix_beat mix_keystream(input logic [OP_W-1:0] op,
                                                input logic [PIX_W-1:0] pix,
                                                input logic last);
        longint unsigned prod;
        int unsigned     m;
        int unsigned     k;
        int unsigned     r;
        t_pix_beat       res;
        prod      = 64'(lcg_state) * 64'(LCG_MULT);
        lcg_state = SEED_W'(prod % 64'(LCG_MOD));
        m = 32'(grey_max) + 1;
        k = 32'(lcg_state) % m;
        if (op == OP_ENC) begin
            r = (32'(pix) + k) % m;
        end else begin
            r = (32'(pix) + m - k) % m;
        end
        res.pixel = PIX_W'(r);
        res.last  = last;
        return res;
    endfunction

    // Counts a failure; only the first few are printed.
    function automatic void report_mismatch(input string what);
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
    endfunction

    // Random seed, with zero and the modulus itself mixed in now and then.
    function automatic logic [SEED_W-1:0] random_seed();
        int unsigned pick;
        pick = $urandom_range(15);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return LCG_MOD;
        end
        return SEED_W'($urandom);
    endfunction

    // Offers one beat, with random idle cycles ahead of it, and predicts on acceptance.
    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic offer_beat(input t_in_beat b, input bit has_want,
                              input logic [PIX_W-1:0] want_pix);
        t_pix_beat want;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.op         <= b.op;
        in_ch.seed_value <= b.seed;
        in_ch.pixel_in   <= b.pix;
        in_ch.last_pixel <= b.last;
        do @(posedge clk); while (!in_ch.ready);
        case (b.op) inside
            OP_SEED: begin
                lcg_state = b.seed;
            end
            OP_ENC, OP_DEC: begin
                want = mix_keystream(b.op, b.pix, b.last);
                if (has_want) begin
                    want.pixel = want_pix;
                end
                expected_pixels.push_back(want);
            end
            default: begin
            end
        endcase
        @(negedge clk);
    endtask

    // Writes the largest grey level; the block must be idle.
    task automatic write_grey_max(input logic [PIX_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        grey_max = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Waits for every expected result, then lets a trailing seed or dropped beat finish.
    task automatic drain_and_settle();
        in_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One random phase: mostly seeded images, with noise beats in between.
    task automatic run_phase(input int unsigned n_items, input logic [PIX_W-1:0] mg,
                             input int unsigned send_pct, input int unsigned stall_in,
                             input bit with_hold);
        int unsigned     done_items;
        int unsigned     len;
        int unsigned     i;
        bit              held;
        logic [OP_W-1:0] img_op;
        t_in_beat        b;
        drain_and_settle();
        write_grey_max(mg);
        send_idle_pct = send_pct;
        stall_pct     = stall_in;
        done_items    = 0;
        held          = 1'b0;
        while (done_items < n_items) begin
            // Long receiver hold-off while the sender keeps offering.
            if (with_hold && !held && done_items >= n_items / 3) begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if ($urandom_range(99) < 85) begin
                // A seed followed by an image whose final pixel carries last, with last now and then flipped.
                b.op   = OP_SEED;
                b.seed = random_seed();
                b.pix  = PIX_W'($urandom);
                b.last = 1'($urandom);
                offer_beat(b, 1'b0, '0);
                done_items++;
                img_op = $urandom_range(1) ? OP_ENC : OP_DEC;
                len    = $urandom_range(24, 1);
                for (i = 1; i <= len; i++) begin
                    b.op = img_op;
                    if ($urandom_range(7) == 0) begin
                        b.op = $urandom_range(1) ? OP_ENC : OP_DEC;
                    end
                    b.seed = SEED_W'($urandom);
                    b.pix  = ($urandom_range(7) == 0) ? PIX_W'($urandom)
                                                      : PIX_W'($urandom_range(mg));
                    b.last = (i == len) ^ ($urandom_range(19) == 0);
                    offer_beat(b, 1'b0, '0);
                    done_items++;
                end
            end else begin
                // Stray beat of any kind, including a seed in the middle of an image.
                b.op   = OP_W'($urandom_range(3));
                b.seed = random_seed();
                b.pix  = PIX_W'($urandom);
                b.last = 1'($urandom);
                offer_beat(b, 1'b0, '0);
                if (b.op != OP_NONE) begin
                    done_items++;
                end
            end
        end
    endtask

    // Output ready: random stalls, or a counted hold-off on request.
    initial begin : result_sink
        int unsigned hold_left;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req     = 1'b0;
                hold_left    = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Compares each result beat with the oldest expectation.
    always @(posedge clk) begin : result_check
        t_pix_beat want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected result pixel %0d last %0d",
                                          out_ch.pixel_out, out_ch.last_out));
            end else begin
                want = expected_pixels.pop_front();
                if (out_ch.pixel_out !== want.pixel) begin
                    report_mismatch($sformatf("pixel expected %0d actual %0d",
                                              want.pixel, out_ch.pixel_out));
                end
                if (out_ch.last_out !== want.last) begin
                    report_mismatch($sformatf("last expected %0d actual %0d",
                                              want.last, out_ch.last_out));
                end
            end
        end
    end

    // Ends the run when no beat moves on any channel for too long. The longest
    // correct silence is the receiver hold-off plus one pixel's latency.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Reset, directed table, random phases, final verdict.
    initial begin : stimulus
        int unsigned       row;
        int unsigned       ph;
        int unsigned       sp;
        int unsigned       st;
        logic [PIX_W-1:0]  mg;
        t_in_beat          b;
        in_ch.valid      = 1'b0;
        in_ch.op         = OP_SEED;
        in_ch.seed_value = '0;
        in_ch.pixel_in   = '0;
        in_ch.last_pixel = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table, no idling.
        for (row = 0; row < DIR_ROWS; row++) begin
            if (directed_rows[row].kind == ROW_CFG) begin
                drain_and_settle();
                write_grey_max(directed_rows[row].pix);
            end else begin
                b.op   = directed_rows[row].op;
                b.seed = directed_rows[row].seed;
                b.pix  = directed_rows[row].pix;
                b.last = directed_rows[row].last;
                offer_beat(b, directed_rows[row].has_want, directed_rows[row].want);
            end
        end

        // Random phases, each with its own largest grey and idling mix.
        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin mg = MAX_GREY_RST;                   sp = 0;  st = 0;  end
                1: begin mg = 16'hFFFF;                       sp = 48; st = 0;  end
                2: begin mg = 16'd1;                          sp = 0;  st = 48; end
                3: begin mg = PIX_W'($urandom_range(65534, 2)); sp = 17; st = 17; end
                4: begin mg = PIX_W'($urandom_range(400, 2));   sp = 0;  st = 48; end
                default: begin
                    mg = PIX_W'($urandom_range(65534, 2));
                    sp = 48;
                    st = 0;
                end
            endcase
            run_phase(PHASE_ITEMS, mg, sp, st, ph == 0);
        end

        drain_and_settle();
        if (fail_count == 0 && expected_pixels.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== pixel_keystream_cipher.f =====
hdl/pkc_pkg.sv
hdl/pkc_if.sv
hdl/pkc_lcg_mul.sv
hdl/pkc_mod_unit.sv
hdl/pixel_keystream_cipher.sv
tb/sv/tb.sv
